// ===== rtl/rmt_pkg.sv =====
`default_nettype none

package rmt_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_RANGE  = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  rtype;
        logic        en;
        logic [3:0]  dtype;
        logic [3:0]  src;
        logic [7:0]  slot;
        logic [1:0]  words;
        logic        ro;
    } t_entry;

    typedef struct packed {
        t_req_kind   kind;
        t_entry      ent;
        logic [16:0] win_end;
        logic [5:0]  max_count;
    } t_req_info;

    typedef struct packed {
        logic    capture;
        logic    step;
        logic    shift_start;
        logic    shift_write;
        logic    write_add;
        logic    dec_count;
        logic    found_inc;
        logic    out_load;
        logic    out_hit;
        logic    out_last;
        logic    out_closing;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        t_req_kind kind;
        logic      ev_valid;
        logic      cursor_done;
        logic      full;
        logic      found_lim;
        logic      m_addr;
        logic      m_type;
        logic      m_en;
        logic      m_rng;
        logic      out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/rmt_ctrl.sv =====
`default_nettype none

module rmt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire rmt_pkg::t_dp_stat i_stat,
    output rmt_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    rmt_pkg::t_status r_fin_status, n_fin_status;
    logic             r_fin_hit, n_fin_hit;
    logic             r_fin_closing, n_fin_closing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_fin_status  <= n_fin_status;
        r_fin_hit     <= n_fin_hit;
        r_fin_closing <= n_fin_closing;
    end

    always_comb begin
        n_state       = r_state;
        n_fin_status  = r_fin_status;
        n_fin_hit     = r_fin_hit;
        n_fin_closing = r_fin_closing;
        o_req_ready   = 1'b0;
        o_cmd         = '0;
        o_cmd.out_status = rmt_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.ev_valid) begin
                    case (i_stat.kind)
                        rmt_pkg::REQ_ADD: begin
                            if (i_stat.m_addr && i_stat.m_type) begin
                                n_fin_status  = rmt_pkg::ST_EXISTS;
                                n_fin_hit     = 1'b0;
                                n_fin_closing = 1'b0;
                                n_state       = S_FINISH;
                            end else begin
                                o_cmd.step = 1'b1;
                            end
                        end
                        rmt_pkg::REQ_REMOVE: begin
                            if (i_stat.m_addr) begin
                                o_cmd.shift_start = 1'b1;
                                n_state           = S_SHIFT;
                            end else begin
                                o_cmd.step = 1'b1;
                            end
                        end
                        rmt_pkg::REQ_LOOKUP: begin
                            if (i_stat.m_addr && i_stat.m_type && i_stat.m_en) begin
                                n_fin_status  = rmt_pkg::ST_OK;
                                n_fin_hit     = 1'b1;
                                n_fin_closing = 1'b0;
                                n_state       = S_FINISH;
                            end else begin
                                o_cmd.step = 1'b1;
                            end
                        end
                        default: begin
                            if (i_stat.found_lim) begin
                                n_fin_status  = rmt_pkg::ST_OK;
                                n_fin_hit     = 1'b0;
                                n_fin_closing = 1'b1;
                                n_state       = S_FINISH;
                            end else if (i_stat.m_rng) begin
                                // A matching entry waits here until the output
                                // register can take it.
                                if (i_stat.out_free) begin
                                    o_cmd.out_load   = 1'b1;
                                    o_cmd.out_hit    = 1'b1;
                                    o_cmd.out_status = rmt_pkg::ST_OK;
                                    o_cmd.found_inc  = 1'b1;
                                    o_cmd.step       = 1'b1;
                                end
                            end else begin
                                o_cmd.step = 1'b1;
                            end
                        end
                    endcase
                end else if (i_stat.cursor_done) begin
                    n_fin_hit     = 1'b0;
                    n_fin_closing = 1'b0;
                    n_state       = S_FINISH;
                    case (i_stat.kind)
                        rmt_pkg::REQ_ADD: begin
                            if (i_stat.full) begin
                                n_fin_status = rmt_pkg::ST_FULL;
                            end else begin
                                o_cmd.write_add = 1'b1;
                                n_fin_status    = rmt_pkg::ST_OK;
                            end
                        end
                        rmt_pkg::REQ_REMOVE: n_fin_status = rmt_pkg::ST_NOT_FOUND;
                        rmt_pkg::REQ_LOOKUP: n_fin_status = rmt_pkg::ST_NOT_FOUND;
                        default: begin
                            n_fin_status  = rmt_pkg::ST_OK;
                            n_fin_closing = 1'b1;
                        end
                    endcase
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_write = i_stat.ev_valid;
                if (!i_stat.ev_valid && i_stat.cursor_done) begin
                    o_cmd.dec_count = 1'b1;
                    n_fin_status    = rmt_pkg::ST_OK;
                    n_fin_hit       = 1'b0;
                    n_fin_closing   = 1'b0;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_hit     = r_fin_hit;
                    o_cmd.out_last    = 1'b1;
                    o_cmd.out_closing = r_fin_closing;
                    o_cmd.out_status  = r_fin_status;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded while the output register is occupied");

    a_shift_only_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (i_stat.kind == rmt_pkg::REQ_REMOVE))
        else $error("table shift outside a remove request");

    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_SCAN) && !i_stat.ev_valid)
        else $error("scan did not start cleanly after a request");

endmodule

`default_nettype wire

// ===== rtl/rmt_datapath.sv =====
`default_nettype none

module rmt_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rmt_pkg::t_dp_cmd                  i_cmd,
    output rmt_pkg::t_dp_stat                      o_stat,
    input  wire rmt_pkg::t_req_info                i_req,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [rmt_pkg::OUT_TDATA_W-1:0]        o_out_data,
    output logic                                   o_out_hit,
    output logic                                   o_out_last
);

    rmt_pkg::t_entry  mem [rmt_pkg::DEPTH];

    rmt_pkg::t_req_info        r_req;
    rmt_pkg::t_entry           r_rd_data;
    logic [rmt_pkg::CW-1:0]    r_count, n_count;
    logic [rmt_pkg::CW-1:0]    r_rd_idx, n_rd_idx;
    logic [rmt_pkg::AW-1:0]    r_ev_idx, n_ev_idx;
    logic                      r_ev_valid, n_ev_valid;
    logic [5:0]                r_found, n_found;
    logic                      r_out_valid, n_out_valid;
    logic [rmt_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                      r_out_hit, r_out_last;

    logic                      cursor_done;
    logic                      rd_en;
    logic                      wr_en;
    logic [rmt_pkg::AW-1:0]    wr_addr;
    rmt_pkg::t_entry           wr_data;
    rmt_pkg::t_entry           out_ent;
    logic [5:0]                out_index;
    logic [5:0]                out_found;

    assign cursor_done = (r_rd_idx == r_count);
    assign rd_en       = i_cmd.step && !cursor_done;

    // The add path writes at the table end; the shift path copies the entry
    // just read one place down.
    assign wr_en   = i_cmd.write_add || i_cmd.shift_write;
    assign wr_addr = i_cmd.write_add ? r_count[rmt_pkg::AW-1:0]
                                     : r_ev_idx - rmt_pkg::AW'(1);
    assign wr_data = i_cmd.write_add ? r_req.ent : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_idx[rmt_pkg::AW-1:0]];
        end
    end

    always_comb begin
        n_rd_idx   = r_rd_idx;
        n_ev_idx   = r_ev_idx;
        n_ev_valid = r_ev_valid;
        n_found    = r_found;
        n_count    = r_count;
        if (i_cmd.capture) begin
            n_rd_idx   = '0;
            n_ev_valid = 1'b0;
            n_found    = '0;
        end else if (i_cmd.shift_start) begin
            n_rd_idx   = rmt_pkg::CW'(r_ev_idx) + rmt_pkg::CW'(1);
            n_ev_valid = 1'b0;
        end else if (i_cmd.step) begin
            if (!cursor_done) begin
                n_ev_valid = 1'b1;
                n_ev_idx   = r_rd_idx[rmt_pkg::AW-1:0];
                n_rd_idx   = r_rd_idx + rmt_pkg::CW'(1);
            end else begin
                n_ev_valid = 1'b0;
            end
        end
        if (i_cmd.found_inc) begin
            n_found = r_found + 6'd1;
        end
        if (i_cmd.write_add) begin
            n_count = r_count + rmt_pkg::CW'(1);
        end else if (i_cmd.dec_count) begin
            n_count = r_count - rmt_pkg::CW'(1);
        end
    end

    always_comb begin
        out_ent   = i_cmd.out_hit ? r_rd_data : '0;
        out_index = i_cmd.out_hit ? 6'(r_ev_idx) : 6'd0;
        out_found = i_cmd.out_closing ? r_found : 6'd0;
        n_out_data = {5'd0, out_found, out_index, out_ent.ro, out_ent.words, out_ent.slot,
                      out_ent.src, out_ent.dtype, out_ent.rtype, out_ent.addr,
                      i_cmd.out_status};
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_ev_valid  <= 1'b0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_ev_valid  <= n_ev_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_ev_idx <= n_ev_idx;
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
            r_out_hit  <= i_cmd.out_hit;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_stat.kind        = r_req.kind;
        o_stat.ev_valid    = r_ev_valid;
        o_stat.cursor_done = cursor_done;
        o_stat.full        = (r_count == rmt_pkg::CW'(rmt_pkg::DEPTH));
        o_stat.found_lim   = (r_found == r_req.max_count);
        o_stat.m_addr      = (r_rd_data.addr == r_req.ent.addr);
        o_stat.m_type      = (r_rd_data.rtype == r_req.ent.rtype);
        o_stat.m_en        = r_rd_data.en;
        o_stat.m_rng       = (r_rd_data.rtype == r_req.ent.rtype) && r_rd_data.en &&
                             (r_rd_data.addr >= r_req.ent.addr) &&
                             ({1'b0, r_rd_data.addr} < r_req.win_end);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_hit   = r_out_hit;
    assign o_out_last  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rmt_pkg::CW'(rmt_pkg::DEPTH))
        else $error("entry count beyond table depth");

    a_eval_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_valid |-> (rmt_pkg::CW'(r_ev_idx) < r_count))
        else $error("evaluated entry lies beyond the filled part of the table");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.found_inc |-> (r_found < r_req.max_count))
        else $error("range query returned more entries than its limit");

endmodule

`default_nettype wire

// ===== rtl/register_mapping_table_unit.sv =====
// Channel   Direction  Payload
// s_axis    in         tuser: req_type; tdata: request fields
// m_axis    out        tuser: hit; tlast: last; tdata: result fields
//
// One request is handled at a time; the table is walked one entry per cycle
// through the single read port of the entry memory.
// A removal that finds its entry moves every later entry down one place in the table.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
// A stalled result register holds the scan; the next request is taken once
// the final result has been loaded into the result register.
`default_nettype none

module register_mapping_table_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] addr, [17:16] reg_kind, [18] enabled, [22:19] value_format,
    // [26:23] source, [34:27] slot, [36:35] word_count, [37] write_lock,
    // [53:38] range_count, [59:54] max_count, [63:60] zero
    input  wire logic [rmt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [1:0] status, [17:2] entry_addr, [19:18] entry_type,
    // [23:20] entry_format, [27:24] entry_source, [35:28] entry_slot,
    // [37:36] entry_words, [38] entry_write_lock, [44:39] entry_index,
    // [50:45] found_count, [55:51] zero
    output logic [rmt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [0] hit
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);

    rmt_pkg::t_dp_cmd   cmd;
    rmt_pkg::t_dp_stat  stat;
    rmt_pkg::t_req_info req;

    always_comb begin
        req.kind          = rmt_pkg::t_req_kind'(s_axis_tuser);
        req.ent.addr      = s_axis_tdata[15:0];
        req.ent.rtype     = s_axis_tdata[17:16];
        req.ent.en        = s_axis_tdata[18];
        req.ent.dtype     = s_axis_tdata[22:19];
        req.ent.src       = s_axis_tdata[26:23];
        req.ent.slot      = s_axis_tdata[34:27];
        req.ent.words     = s_axis_tdata[36:35];
        req.ent.ro        = s_axis_tdata[37];
        // The window end is kept to 17 bits, so it never wraps.
        req.win_end       = {1'b0, s_axis_tdata[15:0]} + {1'b0, s_axis_tdata[53:38]};
        req.max_count     = s_axis_tdata[59:54];
    end

    rmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rmt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (req),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_hit   (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/tb_register_mapping_table_unit.sv =====
`default_nettype none

module tb_register_mapping_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rmt_pkg::*;

    localparam int          RANDOM_REQUESTS = 400;
    localparam int          HOLD_AT         = 120;
    localparam int          HOLD_CYCLES     = 500;
    localparam int          DRAIN_CYCLES    = 2 * DEPTH + 20;
    localparam int unsigned CYCLE_LIMIT     = 2_000_000;

    typedef struct {
        t_req_kind   kind;
        logic [15:0] addr;
        logic [1:0]  rtype;
        logic        en;
        logic [3:0]  dtype;
        logic [3:0]  src;
        logic [7:0]  slot;
        logic [1:0]  words;
        logic        ro;
        logic [15:0] span;
        logic [5:0]  max_count;
    } map_req_t;

    typedef struct {
        t_status     status;
        logic        hit;
        logic [15:0] addr;
        logic [1:0]  rtype;
        logic [3:0]  dtype;
        logic [3:0]  src;
        logic [7:0]  slot;
        logic [1:0]  words;
        logic        ro;
        logic [5:0]  index;
        logic [5:0]  found;
        logic        last;
    } map_result_t;

    class mapping_table_tracker;
        t_entry      table_rows[DEPTH];
        int          rows_used;
        map_result_t awaited[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned full_answers;
        int unsigned dup_answers;
        int unsigned entries_returned;
        int unsigned kind_seen[4];

        function map_result_t plain_answer(t_status st, logic [5:0] found);
            map_result_t r;
            r.status = st;
            r.hit    = 1'b0;
            r.addr   = '0;
            r.rtype  = '0;
            r.dtype  = '0;
            r.src    = '0;
            r.slot   = '0;
            r.words  = '0;
            r.ro     = 1'b0;
            r.index  = '0;
            r.found  = found;
            r.last   = 1'b1;
            return r;
        endfunction

        function map_result_t entry_answer(int pos, logic last);
            map_result_t r;
            r.status = ST_OK;
            r.hit    = 1'b1;
            r.addr   = table_rows[pos].addr;
            r.rtype  = table_rows[pos].rtype;
            r.dtype  = table_rows[pos].dtype;
            r.src    = table_rows[pos].src;
            r.slot   = table_rows[pos].slot;
            r.words  = table_rows[pos].words;
            r.ro     = table_rows[pos].ro;
            r.index  = 6'(pos);
            r.found  = '0;
            r.last   = last;
            return r;
        endfunction

        function string show(map_result_t r);
            return $sformatf(
                "st=%0d hit=%0b addr=%h type=%0d dt=%h src=%h slot=%h w=%0d ro=%0b idx=%0d cnt=%0d last=%0b",
                r.status, r.hit, r.addr, r.rtype, r.dtype, r.src, r.slot, r.words, r.ro,
                r.index, r.found, r.last);
        endfunction

        function void note_request(map_req_t q);
            int          i;
            int          j;
            int          hits;
            logic        done;
            logic [16:0] win_end;
            t_entry      e;
            kind_seen[q.kind]++;
            case (q.kind)
                REQ_ADD: begin
                    done = 1'b0;
                    for (i = 0; i < rows_used; i++)
                        if (table_rows[i].addr == q.addr && table_rows[i].rtype == q.rtype)
                            done = 1'b1;
                    // The duplicate test wins over the full test.
                    if (done) begin
                        awaited.push_back(plain_answer(ST_EXISTS, '0));
                        dup_answers++;
                    end else if (rows_used >= DEPTH) begin
                        awaited.push_back(plain_answer(ST_FULL, '0));
                        full_answers++;
                    end else begin
                        e.addr  = q.addr;
                        e.rtype = q.rtype;
                        e.en    = q.en;
                        e.dtype = q.dtype;
                        e.src   = q.src;
                        e.slot  = q.slot;
                        e.words = q.words;
                        e.ro    = q.ro;
                        table_rows[rows_used] = e;
                        rows_used++;
                        awaited.push_back(plain_answer(ST_OK, '0));
                    end
                end
                REQ_REMOVE: begin
                    done = 1'b0;
                    for (i = 0; i < rows_used && !done; i++) begin
                        if (table_rows[i].addr == q.addr) begin
                            for (j = i; j + 1 < rows_used; j++)
                                table_rows[j] = table_rows[j + 1];
                            rows_used--;
                            done = 1'b1;
                        end
                    end
                    if (done)
                        awaited.push_back(plain_answer(ST_OK, '0));
                    else
                        awaited.push_back(plain_answer(ST_NOT_FOUND, '0));
                end
                REQ_LOOKUP: begin
                    done = 1'b0;
                    for (i = 0; i < rows_used && !done; i++) begin
                        if (table_rows[i].addr == q.addr && table_rows[i].rtype == q.rtype &&
                            table_rows[i].en) begin
                            awaited.push_back(entry_answer(i, 1'b1));
                            entries_returned++;
                            done = 1'b1;
                        end
                    end
                    if (!done)
                        awaited.push_back(plain_answer(ST_NOT_FOUND, '0));
                end
                REQ_RANGE: begin
                    // The window end is 17 bits wide, so it never wraps past 65535.
                    win_end = {1'b0, q.addr} + {1'b0, q.span};
                    hits    = 0;
                    for (i = 0; i < rows_used && hits < q.max_count; i++) begin
                        if (table_rows[i].rtype == q.rtype && table_rows[i].en &&
                            table_rows[i].addr >= q.addr &&
                            {1'b0, table_rows[i].addr} < win_end) begin
                            awaited.push_back(entry_answer(i, 1'b0));
                            entries_returned++;
                            hits++;
                        end
                    end
                    awaited.push_back(plain_answer(ST_OK, 6'(hits)));
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [55:0] d, logic hit, logic last);
            map_result_t e;
            map_result_t a;
            results_seen++;
            a.status = t_status'(d[1:0]);
            a.hit    = hit;
            a.addr   = d[17:2];
            a.rtype  = d[19:18];
            a.dtype  = d[23:20];
            a.src    = d[27:24];
            a.slot   = d[35:28];
            a.words  = d[37:36];
            a.ro     = d[38];
            a.index  = d[44:39];
            a.found  = d[50:45];
            a.last   = last;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Result %0d arrived with no request outstanding: %s",
                             results_seen, show(a));
                return;
            end
            e = awaited.pop_front();
            if (a.status !== e.status || a.hit !== e.hit || a.addr !== e.addr ||
                a.rtype !== e.rtype || a.dtype !== e.dtype || a.src !== e.src ||
                a.slot !== e.slot || a.words !== e.words || a.ro !== e.ro ||
                a.index !== e.index || a.found !== e.found || a.last !== e.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("Result %0d mismatch at %0t", results_seen, $realtime);
                    $display("  expected %s", show(e));
                    $display("  actual   %s", show(a));
                end
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata   = '0;
    logic [1:0]  s_axis_tuser   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    mapping_table_tracker tracker = new;
    int unsigned          requests_sent = 0;

    register_mapping_table_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic map_req_t make_req(t_req_kind kind, logic [15:0] addr,
                                          logic [1:0] rtype, logic en, logic [3:0] dtype,
                                          logic [3:0] src, logic [7:0] slot,
                                          logic [1:0] words, logic ro, logic [15:0] span,
                                          logic [5:0] max_count);
        map_req_t q;
        q.kind      = kind;
        q.addr      = addr;
        q.rtype     = rtype;
        q.en        = en;
        q.dtype     = dtype;
        q.src       = src;
        q.slot      = slot;
        q.words     = words;
        q.ro        = ro;
        q.span      = span;
        q.max_count = max_count;
        return q;
    endfunction

    // Phase 0 fills the table well past full, phase 1 churns it, phase 2 mostly queries.
    function automatic map_req_t random_request(int unsigned phase);
        map_req_t    q;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        case (phase)
            0:       q.kind = pick < 85 ? REQ_ADD : pick < 90 ? REQ_REMOVE :
                              pick < 95 ? REQ_LOOKUP : REQ_RANGE;
            1:       q.kind = pick < 25 ? REQ_ADD : pick < 50 ? REQ_REMOVE :
                              pick < 75 ? REQ_LOOKUP : REQ_RANGE;
            default: q.kind = pick < 15 ? REQ_ADD : pick < 30 ? REQ_REMOVE :
                              pick < 65 ? REQ_LOOKUP : REQ_RANGE;
        endcase
        // Addresses come from a small pool at the bottom, middle and top of the space
        // so that duplicates, hits and removals happen often.
        k = $urandom_range(0, 31);
        if (k < 12)
            q.addr = 16'(k);
        else if (k < 20)
            q.addr = 16'h7FFC + 16'(k - 12);
        else
            q.addr = 16'hFFF4 + 16'(k - 20);
        if (q.kind == REQ_RANGE && $urandom_range(0, 1) == 1)
            q.addr = q.addr - 16'($urandom_range(0, 8));
        if ($urandom_range(0, 99) < 8)
            q.addr = 16'($urandom);
        q.rtype = 2'($urandom_range(0, 3));
        q.en    = ($urandom_range(0, 3) != 0);
        q.dtype = 4'($urandom);
        q.src   = 4'($urandom);
        q.slot  = 8'($urandom);
        q.words = 2'($urandom_range(0, 3));
        q.ro    = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            q.span = '0;
        else if (pick < 60)
            q.span = 16'($urandom_range(1, 24));
        else if (pick < 85)
            q.span = 16'($urandom_range(25, 40000));
        else if (pick < 95)
            q.span = 16'($urandom);
        else
            q.span = 16'hFFFF;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            q.max_count = '0;
        else if (pick < 20)
            q.max_count = 6'($urandom_range(1, 3));
        else if (pick < 80)
            q.max_count = 6'($urandom);
        else
            q.max_count = 6'd63;
        return q;
    endfunction

    task automatic send_request(input map_req_t q);
        int unsigned gap;
        if ((requests_sent / 40) % 3 == 2)
            gap = 0;
        else
            gap = $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= q.kind;
        s_axis_tdata  <= {4'b0, q.max_count, q.span, q.ro, q.words, q.slot, q.src, q.dtype,
                          q.en, q.rtype, q.addr};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tracker.note_request(q);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Result side: random stalls, a quiet stretch every third block of forty results,
    // and one long hold-off that lets the block back up onto its request port.
    initial begin
        int unsigned gap;
        int unsigned n_seen;
        n_seen = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (n_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            else if ((n_seen / 40) % 3 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 14);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
            tracker.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            n_seen++;
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycles, tracker.awaited.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table: every search misses and a range query gives only its closing result.
        send_request(make_req(REQ_LOOKUP, 16'h0000, 2'd0, 1'b1, 4'h0, 4'h0, 8'h00, 2'd1, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_REMOVE, 16'hFFFF, 2'd3, 1'b1, 4'hF, 4'hF, 8'hFF, 2'd2, 1'b1,
                              16'hFFFF, 6'd63));
        send_request(make_req(REQ_RANGE, 16'h0000, 2'd0, 1'b1, 4'h0, 4'h0, 8'h00, 2'd1, 1'b0,
                              16'hFFFF, 6'd63));
        // Extreme entries, including word counts of zero and three.
        send_request(make_req(REQ_ADD, 16'h0000, 2'd0, 1'b1, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_ADD, 16'hFFFF, 2'd3, 1'b1, 4'hF, 4'hF, 8'hFF, 2'd3, 1'b1,
                              16'hFFFF, 6'd63));
        send_request(make_req(REQ_ADD, 16'hFFFF, 2'd3, 1'b0, 4'h5, 4'hA, 8'h5A, 2'd1, 1'b0,
                              16'h1234, 6'd7));
        send_request(make_req(REQ_ADD, 16'hFFFF, 2'd2, 1'b0, 4'h3, 4'hC, 8'hA5, 2'd1, 1'b1,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_ADD, 16'h1234, 2'd1, 1'b1, 4'h9, 4'h6, 8'h3C, 2'd2, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_ADD, 16'h8000, 2'd3, 1'b1, 4'h1, 4'h2, 8'h80, 2'd2, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_LOOKUP, 16'hFFFF, 2'd3, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));
        // A disabled entry is invisible to lookup.
        send_request(make_req(REQ_LOOKUP, 16'hFFFF, 2'd2, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_LOOKUP, 16'h0000, 2'd0, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));
        // A window that would run past the top of the address space stops at its end.
        send_request(make_req(REQ_RANGE, 16'hFFFF, 2'd3, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'hFFFF, 6'd63));
        send_request(make_req(REQ_RANGE, 16'h0000, 2'd0, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd63));
        send_request(make_req(REQ_RANGE, 16'h0000, 2'd3, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'hFFFF, 6'd0));
        send_request(make_req(REQ_RANGE, 16'h0000, 2'd3, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'hFFFF, 6'd1));
        send_request(make_req(REQ_RANGE, 16'h0000, 2'd3, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'hFFFF, 6'd63));
        // Removal ignores the type and takes the first entry with the address.
        send_request(make_req(REQ_REMOVE, 16'hFFFF, 2'd0, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_LOOKUP, 16'hFFFF, 2'd3, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_LOOKUP, 16'h1234, 2'd1, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_ADD, 16'hFFFF, 2'd3, 1'b1, 4'h7, 4'h8, 8'h01, 2'd2, 1'b1,
                              16'h0000, 6'd0));
        send_request(make_req(REQ_REMOVE, 16'h4321, 2'd1, 1'b0, 4'h0, 4'h0, 8'h00, 2'd0, 1'b0,
                              16'h0000, 6'd0));

        for (n = 0; n < RANDOM_REQUESTS; n++)
            send_request(random_request(n < 160 ? 0 : n < 320 ? 1 : 2));
        s_axis_tvalid <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge i_clk);
        // Any stray result would show up during this quiet spell.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (add %0d, remove %0d, lookup %0d, range %0d), %0d results.",
                 requests_sent, tracker.kind_seen[REQ_ADD], tracker.kind_seen[REQ_REMOVE],
                 tracker.kind_seen[REQ_LOOKUP], tracker.kind_seen[REQ_RANGE],
                 tracker.results_seen);
        $display("Saw %0d full-table and %0d duplicate answers, %0d entries returned, %0d errors.",
                 tracker.full_answers, tracker.dup_answers, tracker.entries_returned,
                 tracker.errors);
        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== register_mapping_table_unit.f =====
rtl/rmt_pkg.sv
rtl/rmt_ctrl.sv
rtl/rmt_datapath.sv
rtl/register_mapping_table_unit.sv
dv/tb_register_mapping_table_unit.sv
